// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Synthesis builds define SYNTH to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/mcrtc_pkg.sv =====
package mcrtc_pkg;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // Port offsets from the card's I/O base.
   localparam logic [3:0] PORT_MODE    = 4'd8;
   localparam logic [3:0] PORT_PEN_SET = 4'd9;
   localparam logic [3:0] PORT_STATUS  = 4'd10;
   localparam logic [3:0] PORT_PEN_CLR = 4'd11;
   localparam logic [3:0] PORT_SWITCH  = 4'd15;

   // CRTC register numbers.
   localparam logic [7:0] REG_H_DISPLAYED  = 8'd1;
   localparam logic [7:0] REG_V_TOTAL      = 8'd4;
   localparam logic [7:0] REG_V_ADJUST     = 8'd5;
   localparam logic [7:0] REG_V_DISPLAYED  = 8'd6;
   localparam logic [7:0] REG_V_SYNC_POS   = 8'd7;
   localparam logic [7:0] REG_INTERLACE    = 8'd8;
   localparam logic [7:0] REG_MAX_SCAN     = 8'd9;
   localparam logic [7:0] REG_CURSOR_START = 8'd10;
   localparam logic [7:0] REG_CURSOR_END   = 8'd11;
   localparam logic [7:0] REG_START_HI     = 8'd12;
   localparam logic [7:0] REG_START_LO     = 8'd13;
   localparam logic [7:0] REG_CURSOR_HI    = 8'd14;
   localparam logic [7:0] REG_CURSOR_LO    = 8'd15;

   localparam logic [7:0] STATUS_BASE   = 8'h70;
   localparam logic [7:0] UNMAPPED_READ = 8'hff;

   typedef struct packed {
      logic       en;
      logic [7:0] slot;
      logic [7:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic        mem_sel;
      logic [7:0]  direct_data;
      logic        display_enable;
      logic [15:0] line_address;
      logic [4:0]  row_address;
      logic        in_retrace;
      logic        vertical_sync;
      logic        cursor_visible;
      logic [13:0] cursor_address;
      logic        graphics_mode;
      logic        blink_phase;
   } rsp_info_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        display_enable;
      logic [15:0] line_address;
      logic [4:0]  row_address;
      logic        in_retrace;
      logic        vertical_sync;
      logic        cursor_visible;
      logic [13:0] cursor_address;
      logic        graphics_mode;
      logic        blink_phase;
   } rsp_type;

   // Writable bits of each CRTC register; registers past 17 hold nothing.
   function automatic logic [7:0] reg_mask(input logic [7:0] slot);
      logic [7:0] m;
      unique case (slot)
         8'd0, 8'd1, 8'd2, 8'd3, 8'd13, 8'd15, 8'd16, 8'd17: m = 8'hff;
         8'd4, 8'd6, 8'd7, 8'd10:                           m = 8'h7f;
         8'd5, 8'd9, 8'd11:                                 m = 8'h1f;
         8'd8:                                              m = 8'hf3;
         8'd12, 8'd14:                                      m = 8'h3f;
         default:                                           m = 8'h00;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/mcrtc_chan_if.sv =====
interface mcrtc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [3:0] port;
   logic [7:0] write_data;

   modport source (output valid, command, port, write_data, input ready);
   modport sink (input valid, command, port, write_data, output ready);
endinterface

interface mcrtc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        display_enable;
   logic [15:0] line_address;
   logic [4:0]  row_address;
   logic        in_retrace;
   logic        vertical_sync;
   logic        cursor_visible;
   logic [13:0] cursor_address;
   logic        graphics_mode;
   logic        blink_phase;

   modport source (output valid, read_data, display_enable, line_address, row_address,
                   in_retrace, vertical_sync, cursor_visible, cursor_address,
                   graphics_mode, blink_phase, input ready);
   modport sink (input valid, read_data, display_enable, line_address, row_address,
                 in_retrace, vertical_sync, cursor_visible, cursor_address,
                 graphics_mode, blink_phase, output ready);
endinterface

// ===== rtl/mcrtc_regfile.sv =====
module mcrtc_regfile
   import mcrtc_pkg::*;
#(
   parameter int REGISTER_SLOTS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mem_wr_type                        wr,
   input  logic                              rd_en,
   input  logic [$clog2(REGISTER_SLOTS)-1:0] rd_slot,
   output logic [7:0]                        rd_data
);

   localparam int IdxW = $clog2(REGISTER_SLOTS);

   logic [7:0]                mem [REGISTER_SLOTS];
   logic [REGISTER_SLOTS-1:0] valid_ff;
   logic [REGISTER_SLOTS-1:0] valid_in;
   logic [7:0]                rd_data_ff;
   logic [IdxW-1:0]           wr_slot;

   assign wr_slot = wr.slot[IdxW-1:0];
   assign rd_data = rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr_slot] = 1'b1;
      end
   end

   // An entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_slot] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_slot] ? mem[rd_slot] : 8'h00;
      end
   end

endmodule

// ===== rtl/mcrtc_timing.sv =====
module mcrtc_timing
   import mcrtc_pkg::*;
#(
   parameter int REGISTER_SLOTS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [1:0]                        command,
   input  logic [3:0]                        port,
   input  logic [7:0]                        write_data,
   output mem_wr_type                        mem_wr,
   output logic [$clog2(REGISTER_SLOTS)-1:0] rd_slot,
   output rsp_info_type                      info
);

   localparam int IdxW = $clog2(REGISTER_SLOTS);

   logic [IdxW-1:0] index_ff, index_in;
   logic [7:0]      mode_ff, mode_in;
   logic [7:0]      switch_ff, switch_in;
   logic            pen_ff, pen_in;
   logic [1:0]      status_ff, status_in;
   logic            phase_ff, phase_in;
   logic [4:0]      scan_ff, scan_in;
   logic [6:0]      row_ff, row_in;
   logic [15:0]     addr_ff, addr_in;
   logic [13:0]     row_start_ff, row_start_in;
   logic [4:0]      adjust_ff, adjust_in;
   logic            disp_ff, disp_in;
   logic            cur_line_ff, cur_line_in;
   logic            cur_blink_ff, cur_blink_in;
   logic [4:0]      frame_ff, frame_in;
   logic [12:0]     vsync_ff, vsync_in;

   // CRTC register copies for the timing logic, at writable width; register 8 keeps bits 1:0.
   logic [7:0] r1_ff, r1_in;
   logic [6:0] r4_ff, r4_in;
   logic [4:0] r5_ff, r5_in;
   logic [6:0] r6_ff, r6_in;
   logic [6:0] r7_ff, r7_in;
   logic [1:0] r8_ff, r8_in;
   logic [4:0] r9_ff, r9_in;
   logic [6:0] r10_ff, r10_in;
   logic [4:0] r11_ff, r11_in;
   logic [5:0] r12_ff, r12_in;
   logic [7:0] r13_ff, r13_in;
   logic [5:0] r14_ff, r14_in;
   logic [7:0] r15_ff, r15_in;

   assign rd_slot = index_ff;

   always_comb begin
      cmd_type            cmd;
      logic [7:0]         idx8;
      logic [7:0]         wval;
      logic [7:0]         mc;
      logic [7:0]         stat_rd;
      logic [16:0]        sum;
      logic [5:0]         lines;
      logic [12:0]        prod;
      logic signed [14:0] vcount;
      logic [13:0]        start;
      logic               il;

      cmd    = cmd_type'(command);
      idx8   = 8'(index_ff);
      wval   = write_data & reg_mask(idx8);
      mc     = mode_ff;
      il     = (r8_ff == 2'b11);
      start  = {r12_ff, r13_ff};
      sum    = {1'b0, addr_ff} + {9'd0, r1_ff};
      lines  = il ? {2'b00, r9_ff[4:1]} + 6'd1 : {1'b0, r9_ff} + 6'd1;
      prod   = r4_ff * lines;
      vcount = 15'(prod) + 15'(r5_ff) + 15'sd1 - 15'(r7_ff);

      stat_rd = STATUS_BASE | {6'd0, pen_ff, status_ff[0]};
      if (status_ff[1]) begin
         stat_rd[7] = 1'b1;
         if (!status_ff[0]) begin
            stat_rd[3] = 1'b1;
         end
      end

      index_in     = index_ff;
      mode_in      = mode_ff;
      switch_in    = switch_ff;
      pen_in       = pen_ff;
      status_in    = status_ff;
      phase_in     = phase_ff;
      scan_in      = scan_ff;
      row_in       = row_ff;
      addr_in      = addr_ff;
      row_start_in = row_start_ff;
      adjust_in    = adjust_ff;
      disp_in      = disp_ff;
      cur_line_in  = cur_line_ff;
      cur_blink_in = cur_blink_ff;
      frame_in     = frame_ff;
      vsync_in     = vsync_ff;
      r1_in        = r1_ff;
      r4_in        = r4_ff;
      r5_in        = r5_ff;
      r6_in        = r6_ff;
      r7_in        = r7_ff;
      r8_in        = r8_ff;
      r9_in        = r9_ff;
      r10_in       = r10_ff;
      r11_in       = r11_ff;
      r12_in       = r12_ff;
      r13_in       = r13_ff;
      r14_in       = r14_ff;
      r15_in       = r15_ff;

      mem_wr.en   = 1'b0;
      mem_wr.slot = idx8;
      mem_wr.data = wval;

      info.mem_sel     = 1'b0;
      info.direct_data = UNMAPPED_READ;

      unique case (cmd)
         CMD_TICK: begin
            if (!phase_ff) begin
               status_in[0] = 1'b1;
               phase_in     = 1'b1;
               if (disp_ff) begin
                  if (mode_ff[1]) begin
                     addr_in = sum[15:0];
                  end else if (r1_ff != 8'd0) begin
                     addr_in = switch_ff[0] ? {2'b00, sum[13:0]} : {5'd0, sum[10:0]};
                  end
               end
               if (row_ff == r7_ff && scan_ff == 5'd0) begin
                  status_in[1] = 1'b1;
               end
            end else begin
               if (disp_ff) begin
                  status_in[0] = 1'b0;
               end
               phase_in = 1'b0;
               if (vsync_ff != 13'd0) begin
                  vsync_in = vsync_ff - 13'd1;
                  if (vsync_ff == 13'd1) begin
                     status_in[1] = 1'b0;
                  end
               end
               if (scan_ff == r11_ff || (il && scan_ff == {1'b0, r11_ff[4:1]})) begin
                  cur_line_in = 1'b0;
               end

               if (adjust_ff != 5'd0) begin
                  // Vertical total adjust lines keep replaying the last row start.
                  scan_in   = scan_ff + 5'd1;
                  addr_in   = {2'b00, row_start_ff};
                  adjust_in = adjust_ff - 5'd1;
                  if (adjust_ff == 5'd1) begin
                     disp_in      = 1'b1;
                     row_start_in = start;
                     addr_in      = {2'b00, start};
                     scan_in      = 5'd0;
                  end
               end else if ((!il && scan_ff == r9_ff) ||
                            (il && scan_ff == {1'b0, r9_ff[4:1]})) begin
                  row_start_in = addr_ff[13:0];
                  scan_in      = 5'd0;
                  row_in       = row_ff + 7'd1;
                  if (row_in == r6_ff) begin
                     disp_in = 1'b0;
                  end
                  if (row_ff == r4_ff) begin
                     row_in    = 7'd0;
                     adjust_in = r5_ff;
                     if (r5_ff == 5'd0) begin
                        disp_in      = 1'b1;
                        row_start_in = start;
                        addr_in      = {2'b00, start};
                     end
                     unique case (r10_ff[6:5])
                        2'b01:   cur_blink_in = 1'b0;
                        2'b11:   cur_blink_in = frame_ff[4];
                        default: cur_blink_in = frame_ff[3];
                     endcase
                  end
                  if (row_in == r7_ff) begin
                     disp_in  = 1'b0;
                     vsync_in = (!vcount[14] && vcount != 15'sd0) ? vcount[12:0] : 13'd0;
                     frame_in = frame_ff + 5'd1;
                  end
               end else begin
                  scan_in = scan_ff + 5'd1;
                  addr_in = {2'b00, row_start_ff};
               end

               if (scan_in == r10_ff[4:0] || (il && scan_in == {1'b0, r10_ff[4:1]})) begin
                  cur_line_in = 1'b1;
               end
            end
         end
         CMD_WRITE: begin
            if (!port[3] && !port[0]) begin
               index_in = write_data[IdxW-1:0];
            end else if (!port[3]) begin
               mem_wr.en = accept;
               unique case (idx8)
                  REG_H_DISPLAYED:  r1_in  = wval;
                  REG_V_TOTAL:      r4_in  = wval[6:0];
                  REG_V_ADJUST:     r5_in  = wval[4:0];
                  REG_V_DISPLAYED:  r6_in  = wval[6:0];
                  REG_V_SYNC_POS:   r7_in  = wval[6:0];
                  REG_INTERLACE:    r8_in  = wval[1:0];
                  REG_MAX_SCAN:     r9_in  = wval[4:0];
                  REG_CURSOR_START: r10_in = wval[6:0];
                  REG_CURSOR_END:   r11_in = wval[4:0];
                  REG_START_HI:     r12_in = wval[5:0];
                  REG_START_LO:     r13_in = wval;
                  REG_CURSOR_HI:    r14_in = wval[5:0];
                  REG_CURSOR_LO:    r15_in = wval;
                  default: ;
               endcase
               // A cursor of lines 6 to 7 is moved to the card's native lines 11 to 12.
               if (r10_in == 7'd6 && r11_in == 5'd7) begin
                  r10_in = 7'h0b;
                  r11_in = 5'h0c;
               end
            end else begin
               unique case (port)
                  PORT_MODE: begin
                     // Graphics and page bits can only be turned on when the switch allows it.
                     if (mode_ff[1] && !write_data[1]) begin
                        mc[1] = 1'b0;
                     end else if (write_data[1] && switch_ff[0]) begin
                        mc[1] = 1'b1;
                     end
                     if (mode_ff[7] && !write_data[7]) begin
                        mc[7] = 1'b0;
                     end else if (write_data[7] && switch_ff[1]) begin
                        mc[7] = 1'b1;
                     end
                     mode_in = (mc & 8'h82) | (write_data & 8'h7d);
                  end
                  PORT_PEN_SET: pen_in    = 1'b1;
                  PORT_PEN_CLR: pen_in    = 1'b0;
                  PORT_SWITCH:  switch_in = write_data;
                  default: ;
               endcase
            end
         end
         CMD_READ: begin
            if (!port[3] && !port[0]) begin
               info.direct_data = idx8;
            end else if (!port[3]) begin
               // The start address registers read back the live address counter.
               unique case (idx8)
                  REG_START_HI:     info.direct_data = {2'b00, addr_ff[13:8]};
                  REG_START_LO:     info.direct_data = addr_ff[7:0];
                  REG_CURSOR_START: info.direct_data = {1'b0, r10_ff};
                  REG_CURSOR_END:   info.direct_data = {3'b000, r11_ff};
                  default:          info.mem_sel     = 1'b1;
               endcase
            end else if (port == PORT_STATUS) begin
               info.direct_data = stat_rd;
            end
         end
         CMD_NONE: ;
         default: ;
      endcase

      info.display_enable = disp_ff;
      info.line_address   = addr_ff;
      info.row_address    = scan_ff;
      info.in_retrace     = status_in[0];
      info.vertical_sync  = status_in[1];
      info.cursor_visible = cur_line_in & cur_blink_in;
      info.cursor_address = {r14_in, r15_in};
      info.graphics_mode  = mode_in[1];
      info.blink_phase    = frame_in[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff     <= '0;
         mode_ff      <= '0;
         switch_ff    <= '0;
         pen_ff       <= 1'b0;
         status_ff    <= '0;
         phase_ff     <= 1'b0;
         scan_ff      <= '0;
         row_ff       <= '0;
         addr_ff      <= '0;
         row_start_ff <= '0;
         adjust_ff    <= '0;
         disp_ff      <= 1'b0;
         cur_line_ff  <= 1'b0;
         cur_blink_ff <= 1'b0;
         frame_ff     <= '0;
         vsync_ff     <= '0;
         r1_ff        <= '0;
         r4_ff        <= '0;
         r5_ff        <= '0;
         r6_ff        <= '0;
         r7_ff        <= '0;
         r8_ff        <= '0;
         r9_ff        <= '0;
         r10_ff       <= '0;
         r11_ff       <= '0;
         r12_ff       <= '0;
         r13_ff       <= '0;
         r14_ff       <= '0;
         r15_ff       <= '0;
      end else if (accept) begin
         index_ff     <= index_in;
         mode_ff      <= mode_in;
         switch_ff    <= switch_in;
         pen_ff       <= pen_in;
         status_ff    <= status_in;
         phase_ff     <= phase_in;
         scan_ff      <= scan_in;
         row_ff       <= row_in;
         addr_ff      <= addr_in;
         row_start_ff <= row_start_in;
         adjust_ff    <= adjust_in;
         disp_ff      <= disp_in;
         cur_line_ff  <= cur_line_in;
         cur_blink_ff <= cur_blink_in;
         frame_ff     <= frame_in;
         vsync_ff     <= vsync_in;
         r1_ff        <= r1_in;
         r4_ff        <= r4_in;
         r5_ff        <= r5_in;
         r6_ff        <= r6_in;
         r7_ff        <= r7_in;
         r8_ff        <= r8_in;
         r9_ff        <= r9_in;
         r10_ff       <= r10_in;
         r11_ff       <= r11_in;
         r12_ff       <= r12_in;
         r13_ff       <= r13_in;
         r14_ff       <= r14_in;
         r15_ff       <= r15_in;
      end
   end

endmodule

// ===== rtl/mono_crtc_timing_and_ports_core.sv =====
// Monochrome CRTC timing core with its I/O port register file.
// The request channel carries one beat per port write, port read or half-line
// tick; the response channel returns exactly one beat per request, in order.
// A response carries the read byte (0xff for anything but a mapped read), the
// display, address and scanline state from before the beat, and the retrace,
// vsync, cursor, mode and blink state from after it.
// One request is taken every cycle while req ready is high: the timing state
// updates in the accept cycle, the register file memory is read at the
// current index in that same cycle, and the registered memory data joins the
// response in the next stage.
// Two response slots exist, so a new request is still taken while a finished
// response waits; when both slots are full and the receiver holds ready low,
// req ready drops until a beat drains.
// Reset clears every counter and flag and marks all register file entries as
// unwritten, which read as zero; no clearing pass is needed, and the block
// takes requests in the first cycle after reset.
`include "assert_macros.svh"

module mono_crtc_timing_and_ports_core
   import mcrtc_pkg::*;
#(
   parameter int REGISTER_SLOTS = 32
) (
   input logic         clock,
   input logic         reset,
   mcrtc_req_if.sink   req_ch,
   mcrtc_rsp_if.source rsp_ch
);

   localparam int IdxW = $clog2(REGISTER_SLOTS);

   mem_wr_type      mem_wr;
   logic [IdxW-1:0] rd_slot;
   logic [7:0]      mem_rd_data;
   rsp_info_type    info;

   rsp_info_type    s1_info_ff;
   logic            s1_valid_ff, s1_valid_in;
   rsp_type         out_ff, out_in;
   logic            out_valid_ff, out_valid_in;

   logic            out_adv;
   logic            req_ready;
   logic            req_accept;

   assign out_adv    = !out_valid_ff || rsp_ch.ready;
   assign req_ready  = !s1_valid_ff || out_adv;
   assign req_accept = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;

   mcrtc_timing #(
      .REGISTER_SLOTS(REGISTER_SLOTS)
   ) u_timing (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .command   (req_ch.command),
      .port      (req_ch.port),
      .write_data(req_ch.write_data),
      .mem_wr    (mem_wr),
      .rd_slot   (rd_slot),
      .info      (info)
   );

   mcrtc_regfile #(
      .REGISTER_SLOTS(REGISTER_SLOTS)
   ) u_regfile (
      .clock  (clock),
      .reset  (reset),
      .wr     (mem_wr),
      .rd_en  (req_accept),
      .rd_slot(rd_slot),
      .rd_data(mem_rd_data)
   );

   always_comb begin
      s1_valid_in = req_accept || (s1_valid_ff && !out_adv);
      out_valid_in = out_adv ? s1_valid_ff : out_valid_ff;

      out_in.read_data      = s1_info_ff.mem_sel ? mem_rd_data : s1_info_ff.direct_data;
      out_in.display_enable = s1_info_ff.display_enable;
      out_in.line_address   = s1_info_ff.line_address;
      out_in.row_address    = s1_info_ff.row_address;
      out_in.in_retrace     = s1_info_ff.in_retrace;
      out_in.vertical_sync  = s1_info_ff.vertical_sync;
      out_in.cursor_visible = s1_info_ff.cursor_visible;
      out_in.cursor_address = s1_info_ff.cursor_address;
      out_in.graphics_mode  = s1_info_ff.graphics_mode;
      out_in.blink_phase    = s1_info_ff.blink_phase;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_info_ff <= info;
      end
      if (out_adv && s1_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.read_data      = out_ff.read_data;
   assign rsp_ch.display_enable = out_ff.display_enable;
   assign rsp_ch.line_address   = out_ff.line_address;
   assign rsp_ch.row_address    = out_ff.row_address;
   assign rsp_ch.in_retrace     = out_ff.in_retrace;
   assign rsp_ch.vertical_sync  = out_ff.vertical_sync;
   assign rsp_ch.cursor_visible = out_ff.cursor_visible;
   assign rsp_ch.cursor_address = out_ff.cursor_address;
   assign rsp_ch.graphics_mode  = out_ff.graphics_mode;
   assign rsp_ch.blink_phase    = out_ff.blink_phase;

   // A held beat in the first stage must keep its memory data as well as its fields.
   `ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !out_adv, s1_valid_ff && $stable(s1_info_ff) && $stable(mem_rd_data), "stalled first-stage beat changed")
   `ASSERT_NEXT(a_accept_fills, clock, reset, req_accept, s1_valid_ff, "accepted beat was lost")
   `ASSERT_NEXT(a_s1_moves, clock, reset, s1_valid_ff && out_adv, out_valid_ff, "first-stage beat did not reach the output")
   `ASSERT_IMPLIES(a_ready_room, clock, reset, req_ready, !s1_valid_ff || !out_valid_ff || rsp_ch.ready, "request taken with both slots full")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import mcrtc_pkg::*;

   // The index and data ports of the CRTC repeat across offsets 0..7, so only
   // bits 3 and 0 of the offset tell them apart.
   localparam logic [3:0] PORT_INDEX  = 4'd0;
   localparam logic [3:0] PORT_DATA   = 4'd1;
   localparam logic [3:0] PORT_MIRROR = 4'b1001;

   localparam logic [7:0] BLINK_FIELD = 8'h60;
   localparam logic [7:0] BLINK_OFF   = 8'h20;
   localparam logic [7:0] BLINK_SLOW  = 8'h60;

   localparam int ITEM_TARGET = 1800;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AT     = 400;
   localparam int IDLE_PCT    = 32;

   // Writable bits per register, entry 31 first.
   localparam logic [31:0][7:0] WRITE_MASK = {
      {14{8'h00}}, 8'hff, 8'hff, 8'hff, 8'h3f, 8'hff, 8'h3f, 8'h1f, 8'h7f, 8'h1f,
      8'hf3, 8'h7f, 8'h7f, 8'h1f, 8'h7f, 8'hff, 8'hff, 8'hff, 8'hff};

   typedef struct packed {
      cmd_type    cmd;
      logic [3:0] port;
      logic [7:0] data;
   } bus_op_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mcrtc_req_if req_bus ();
   mcrtc_rsp_if rsp_bus ();

   mono_crtc_timing_and_ports_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Tracked CRTC state.
   logic [7:0]  crtc_reg [32];
   logic [4:0]  reg_idx;
   logic [7:0]  mode_ctl;
   logic [7:0]  cfg_switch;
   logic        pen_flag;
   logic [1:0]  stat;
   logic        half_phase;
   logic [4:0]  scan;
   logic [6:0]  row;
   logic [15:0] addr;
   logic [13:0] row_start;
   logic [4:0]  adj_left;
   logic        disp_on;
   logic        cur_line;
   logic        cur_blink;
   logic [4:0]  frame_cnt;
   logic [12:0] vs_left;

   bus_op_type bus_ops [$];
   rsp_type rsp_beats_due [$];
   bus_op_type next_op;
   rsp_type want;

   int  req_count = 0;
   int  rsp_count = 0;
   int  n_ticks = 0;
   int  n_reads = 0;
   int  n_writes = 0;
   int  frames_done = 0;
   int  mismatches = 0;
   int  quiet_cycles = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   logic req_took;

   wire steady_stretch = (req_count >= 700) && (req_count < 1000);

   task automatic clear_crtc();
      foreach (crtc_reg[i]) crtc_reg[i] = 8'h00;
      reg_idx = '0;
      mode_ctl = '0;
      cfg_switch = '0;
      pen_flag = 1'b0;
      stat = '0;
      half_phase = 1'b0;
      scan = '0;
      row = '0;
      addr = '0;
      row_start = '0;
      adj_left = '0;
      disp_on = 1'b0;
      cur_line = 1'b0;
      cur_blink = 1'b0;
      frame_cnt = '0;
      vs_left = '0;
   endtask

   task automatic reload_start();
      disp_on = 1'b1;
      row_start = {crtc_reg[REG_START_HI[4:0]][5:0], crtc_reg[REG_START_LO[4:0]]};
      addr = {2'b00, row_start};
   endtask

   task automatic crtc_step(input cmd_type cmd, input logic [3:0] port,
                            input logic [7:0] data, output rsp_type r);
      logic       il;
      logic [4:0] cstart;
      logic [4:0] cend;
      logic [6:0] prev_row;
      logic [7:0] keep;
      logic [7:0] status;
      logic [16:0] sum;
      int         lines;
      int         v_total;
      int         v_adjust;
      int         v_sync;
      int         span;
      r.read_data = UNMAPPED_READ;
      r.display_enable = disp_on;
      r.line_address = addr;
      r.row_address = scan;
      case (cmd)
         CMD_TICK: begin
            if (!half_phase) begin
               stat[0] = 1'b1;
               half_phase = 1'b1;
               if (disp_on) begin
                  sum = {1'b0, addr} + {9'd0, crtc_reg[REG_H_DISPLAYED[4:0]]};
                  if (mode_ctl[1]) begin
                     addr = sum[15:0];
                  end else if (crtc_reg[REG_H_DISPLAYED[4:0]] != 8'h00) begin
                     addr = cfg_switch[0] ? {2'b00, sum[13:0]} : {5'b00000, sum[10:0]};
                  end
               end
               if (row == crtc_reg[REG_V_SYNC_POS[4:0]][6:0] && scan == 5'd0) stat[1] = 1'b1;
            end else begin
               il = (crtc_reg[REG_INTERLACE[4:0]][1:0] == 2'b11);
               cend = crtc_reg[REG_CURSOR_END[4:0]][4:0];
               cstart = crtc_reg[REG_CURSOR_START[4:0]][4:0];
               if (disp_on) stat[0] = 1'b0;
               half_phase = 1'b0;
               if (vs_left != 13'd0) begin
                  vs_left = vs_left - 13'd1;
                  if (vs_left == 13'd0) stat[1] = 1'b0;
               end
               if (scan == cend || (il && scan == (cend >> 1))) cur_line = 1'b0;
               if (adj_left != 5'd0) begin
                  scan = scan + 5'd1;
                  addr = {2'b00, row_start};
                  adj_left = adj_left - 5'd1;
                  if (adj_left == 5'd0) begin
                     reload_start();
                     scan = '0;
                  end
               end else if ((!il && scan == crtc_reg[REG_MAX_SCAN[4:0]][4:0]) ||
                            (il && scan == {1'b0, crtc_reg[REG_MAX_SCAN[4:0]][4:1]})) begin
                  prev_row = row;
                  row_start = addr[13:0];
                  scan = '0;
                  row = row + 7'd1;
                  if (row == crtc_reg[REG_V_DISPLAYED[4:0]][6:0]) disp_on = 1'b0;
                  if (prev_row == crtc_reg[REG_V_TOTAL[4:0]][6:0]) begin
                     row = '0;
                     adj_left = crtc_reg[REG_V_ADJUST[4:0]][4:0];
                     if (adj_left == 5'd0) reload_start();
                     case (crtc_reg[REG_CURSOR_START[4:0]] & BLINK_FIELD)
                        BLINK_OFF:  cur_blink = 1'b0;
                        BLINK_SLOW: cur_blink = frame_cnt[4];
                        default:    cur_blink = frame_cnt[3];
                     endcase
                  end
                  if (row == crtc_reg[REG_V_SYNC_POS[4:0]][6:0]) begin
                     lines = il ? int'(crtc_reg[REG_MAX_SCAN[4:0]][4:1]) + 1
                                : int'(crtc_reg[REG_MAX_SCAN[4:0]][4:0]) + 1;
                     v_total = int'(crtc_reg[REG_V_TOTAL[4:0]]);
                     v_adjust = int'(crtc_reg[REG_V_ADJUST[4:0]]);
                     v_sync = int'(crtc_reg[REG_V_SYNC_POS[4:0]]);
                     span = v_total * lines + v_adjust - v_sync + 1;
                     disp_on = 1'b0;
                     vs_left = (span > 0) ? span[12:0] : '0;
                     frame_cnt = frame_cnt + 5'd1;
                     frames_done++;
                  end
               end else begin
                  scan = scan + 5'd1;
                  addr = {2'b00, row_start};
               end
               if (scan == cstart || (il && scan == (cstart >> 1))) cur_line = 1'b1;
            end
         end
         CMD_WRITE: begin
            if ((port & PORT_MIRROR) == PORT_INDEX) begin
               reg_idx = data[4:0];
            end else if ((port & PORT_MIRROR) == PORT_DATA) begin
               crtc_reg[reg_idx] = data & WRITE_MASK[reg_idx];
               // A start/end pair of 6/7 is moved to 11/12 to suit the mono font.
               if (crtc_reg[REG_CURSOR_START[4:0]] == 8'd6 &&
                   crtc_reg[REG_CURSOR_END[4:0]] == 8'd7) begin
                  crtc_reg[REG_CURSOR_START[4:0]] = 8'h0b;
                  crtc_reg[REG_CURSOR_END[4:0]] = 8'h0c;
               end
            end else if (port == PORT_MODE) begin
               keep = mode_ctl;
               if (mode_ctl[1] && !data[1]) keep[1] = 1'b0;
               else if (data[1] && cfg_switch[0]) keep[1] = 1'b1;
               if (mode_ctl[7] && !data[7]) keep[7] = 1'b0;
               else if (data[7] && cfg_switch[1]) keep[7] = 1'b1;
               mode_ctl = (keep & 8'h82) | (data & 8'h7d);
            end else if (port == PORT_PEN_SET) begin
               pen_flag = 1'b1;
            end else if (port == PORT_PEN_CLR) begin
               pen_flag = 1'b0;
            end else if (port == PORT_SWITCH) begin
               cfg_switch = data;
            end
         end
         CMD_READ: begin
            if ((port & PORT_MIRROR) == PORT_INDEX) begin
               r.read_data = {3'b000, reg_idx};
            end else if ((port & PORT_MIRROR) == PORT_DATA) begin
               if (reg_idx == REG_START_HI[4:0]) r.read_data = {2'b00, addr[13:8]};
               else if (reg_idx == REG_START_LO[4:0]) r.read_data = addr[7:0];
               else r.read_data = crtc_reg[reg_idx];
            end else if (port == PORT_STATUS) begin
               status = STATUS_BASE | {6'b000000, pen_flag, stat[0]};
               if (stat[1]) status[7] = 1'b1;
               if (stat[1] && !stat[0]) status[3] = 1'b1;
               r.read_data = status;
            end
         end
         default: ;
      endcase
      r.in_retrace = stat[0];
      r.vertical_sync = stat[1];
      r.cursor_visible = cur_line && cur_blink;
      r.cursor_address = {crtc_reg[REG_CURSOR_HI[4:0]][5:0], crtc_reg[REG_CURSOR_LO[4:0]]};
      r.graphics_mode = mode_ctl[1];
      r.blink_phase = frame_cnt[4];
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("beat %0d: %s expected %0h, got %0h", rsp_count, name, exp_v, act_v);
      end
   endtask

   task automatic push_op(input cmd_type cmd, input logic [3:0] port, input logic [7:0] data);
      bus_op_type op;
      op.cmd = cmd;
      op.port = port;
      op.data = data;
      bus_ops.push_back(op);
   endtask

   // Picks one of the four mirrored offsets of the index or data port.
   function automatic logic [3:0] crtc_port(input logic [3:0] base);
      logic [3:0] m;
      m = 4'($urandom_range(3));
      return base | (m << 1);
   endfunction

   task automatic set_reg(input logic [7:0] num, input logic [7:0] value);
      logic [7:0] idx_byte;
      idx_byte = 8'($urandom);
      idx_byte[4:0] = num[4:0];
      push_op(CMD_WRITE, crtc_port(PORT_INDEX), idx_byte);
      push_op(CMD_WRITE, crtc_port(PORT_DATA), value);
   endtask

   // Response beats are checked against the prediction made when their request was accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
         clear_crtc();
      end else begin
         req_took <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rsp_beats_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("response beat %0d with nothing outstanding",
                                              rsp_count);
            end else begin
               want = rsp_beats_due.pop_front();
               check_field("read_data", 16'(want.read_data), 16'(rsp_bus.read_data));
               check_field("display_enable", 16'(want.display_enable),
                           16'(rsp_bus.display_enable));
               check_field("line_address", want.line_address, rsp_bus.line_address);
               check_field("row_address", 16'(want.row_address), 16'(rsp_bus.row_address));
               check_field("in_retrace", 16'(want.in_retrace), 16'(rsp_bus.in_retrace));
               check_field("vertical_sync", 16'(want.vertical_sync),
                           16'(rsp_bus.vertical_sync));
               check_field("cursor_visible", 16'(want.cursor_visible),
                           16'(rsp_bus.cursor_visible));
               check_field("cursor_address", 16'(want.cursor_address),
                           16'(rsp_bus.cursor_address));
               check_field("graphics_mode", 16'(want.graphics_mode),
                           16'(rsp_bus.graphics_mode));
               check_field("blink_phase", 16'(want.blink_phase), 16'(rsp_bus.blink_phase));
            end
            rsp_count++;
         end
         if (req_bus.valid && req_bus.ready) begin
            case (cmd_type'(req_bus.command))
               CMD_TICK:  n_ticks++;
               CMD_READ:  n_reads++;
               CMD_WRITE: n_writes++;
               default: ;
            endcase
            crtc_step(cmd_type'(req_bus.command), req_bus.port, req_bus.write_data, want);
            rsp_beats_due.push_back(want);
            req_count++;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_took) begin
         if (bus_ops.size() != 0 && (steady_stretch || $urandom_range(99) >= IDLE_PCT)) begin
            next_op = bus_ops.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.command <= next_op.cmd;
            req_bus.port <= next_op.port;
            req_bus.write_data <= next_op.data;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // The receiver holds off once for a long stretch so the block backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && rsp_count >= HOLD_AT) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_bus.ready <= steady_stretch || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      int         vt;
      int         ms;
      int         adj;
      int         pick;
      int         body;
      int         k;
      int         roll;
      logic [7:0] v;
      logic [3:0] p;

      req_bus.valid = 1'b0;
      req_bus.command = CMD_TICK;
      req_bus.port = 4'd0;
      req_bus.write_data = 8'h00;
      rsp_bus.ready = 1'b0;

      // Directed beats: reset values, mode gating, light pen, cursor fix-up,
      // the top register slot, ignored ports and the unused command.
      push_op(CMD_READ, PORT_STATUS, 8'h00);
      push_op(CMD_READ, crtc_port(PORT_INDEX), 8'h00);
      push_op(CMD_READ, crtc_port(PORT_DATA), 8'h00);
      push_op(CMD_READ, PORT_MODE, 8'h00);
      push_op(CMD_WRITE, PORT_MODE, 8'hff);
      push_op(CMD_WRITE, PORT_SWITCH, 8'h03);
      push_op(CMD_WRITE, PORT_MODE, 8'h82);
      push_op(CMD_WRITE, PORT_MODE, 8'h00);
      push_op(CMD_WRITE, PORT_SWITCH, 8'h00);
      push_op(CMD_WRITE, PORT_PEN_SET, 8'h00);
      push_op(CMD_READ, PORT_STATUS, 8'hff);
      push_op(CMD_WRITE, PORT_PEN_CLR, 8'hff);
      push_op(CMD_READ, PORT_STATUS, 8'h00);
      set_reg(REG_CURSOR_START, 8'd6);
      set_reg(REG_CURSOR_END, 8'd7);
      push_op(CMD_READ, crtc_port(PORT_DATA), 8'h00);
      push_op(CMD_WRITE, crtc_port(PORT_INDEX), 8'hff);
      push_op(CMD_WRITE, crtc_port(PORT_DATA), 8'hff);
      push_op(CMD_READ, crtc_port(PORT_DATA), 8'h00);
      for (p = PORT_PEN_CLR + 4'd1; p != PORT_SWITCH; p++) push_op(CMD_WRITE, p, 8'hff);
      push_op(CMD_NONE, PORT_STATUS, 8'hff);
      push_op(CMD_TICK, 4'd0, 8'h00);
      push_op(CMD_TICK, 4'hf, 8'hff);

      // Random part: program a small frame geometry, then run mostly ticks
      // with port traffic mixed in. A few segments use extreme geometry.
      while (bus_ops.size() < ITEM_TARGET) begin
         vt = $urandom_range(4);
         ms = $urandom_range(3);
         adj = $urandom_range(2);
         pick = $urandom_range(11);
         if (pick == 0) begin
            vt = 127;
            ms = 0;
         end else if (pick == 1) begin
            ms = 31;
         end else if (pick == 2) begin
            adj = 31;
         end
         set_reg(REG_H_DISPLAYED, 8'($urandom));
         v = 8'($urandom); v[6:0] = 7'(vt);                     set_reg(REG_V_TOTAL, v);
         v = 8'($urandom); v[4:0] = 5'(adj);                    set_reg(REG_V_ADJUST, v);
         v = 8'($urandom); v[6:0] = 7'($urandom_range(vt + 2)); set_reg(REG_V_DISPLAYED, v);
         v = 8'($urandom); v[6:0] = 7'($urandom_range(vt + 3)); set_reg(REG_V_SYNC_POS, v);
         set_reg(REG_INTERLACE, 8'($urandom));
         v = 8'($urandom); v[4:0] = 5'(ms);                     set_reg(REG_MAX_SCAN, v);
         if ($urandom_range(5) == 0) begin
            set_reg(REG_CURSOR_START, 8'd6);
            set_reg(REG_CURSOR_END, 8'd7);
         end else begin
            set_reg(REG_CURSOR_START, 8'($urandom));
            set_reg(REG_CURSOR_END, 8'($urandom));
         end
         set_reg(REG_START_HI, 8'($urandom));
         set_reg(REG_START_LO, 8'($urandom));
         set_reg(REG_CURSOR_HI, 8'($urandom));
         set_reg(REG_CURSOR_LO, 8'($urandom));
         if ($urandom_range(2) == 0) set_reg(8'($urandom_range(31)), 8'($urandom));
         if ($urandom_range(1) == 0) begin
            push_op(CMD_WRITE, PORT_SWITCH, 8'($urandom));
            push_op(CMD_WRITE, PORT_MODE, 8'($urandom));
         end
         push_op(CMD_WRITE, crtc_port(PORT_INDEX), 8'($urandom));
         body = $urandom_range(50, 130);
         for (k = 0; k < body; k++) begin
            roll = $urandom_range(99);
            if (roll < 78) push_op(CMD_TICK, 4'($urandom), 8'($urandom));
            else if (roll < 88) push_op(CMD_READ, 4'($urandom), 8'($urandom));
            else if (roll < 97) push_op(CMD_WRITE, 4'($urandom), 8'($urandom));
            else push_op(CMD_NONE, 4'($urandom), 8'($urandom));
         end
      end

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (bus_ops.size() != 0 || req_bus.valid || rsp_beats_due.size() != 0);
      repeat (8) @(posedge clock);

      $display("Run sent %0d beats: %0d half-line ticks, %0d port reads, %0d port writes.",
               req_count, n_ticks, n_reads, n_writes);
      $display("It checked %0d response beats across %0d frames, with %0d field mismatches.",
               rsp_count, frames_done, mismatches);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mcrtc_pkg.sv
rtl/mcrtc_chan_if.sv
rtl/mcrtc_regfile.sv
rtl/mcrtc_timing.sv
rtl/mono_crtc_timing_and_ports_core.sv
sim/tb.sv
